// ===== hdl/rc4_pkg.sv =====
// Shared types, action codes and the microcode program for the RC4 cipher block.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package rc4_pkg;

  typedef logic [7:0] byte_t;

  localparam int SBOX_DEPTH = 256;
  localparam int PC_W       = 4;

  typedef logic [PC_W-1:0] pc_t;

  // Action codes carried by an input item
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_INIT  = 2'd1;
  localparam logic [1:0] ACT_CRYPT = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  // Port A address select
  localparam logic [1:0] A_I1   = 2'd0;  // i + 1
  localparam logic [1:0] A_JSUM = 2'd1;  // j + S[i]
  localparam logic [1:0] A_N    = 2'd2;  // schedule counter
  localparam logic [1:0] A_KSUM = 2'd3;  // acc + S[n] + key

  // Write address select
  localparam logic [1:0] W_I   = 2'd0;
  localparam logic [1:0] W_J   = 2'd1;
  localparam logic [1:0] W_N   = 2'd2;
  localparam logic [1:0] W_ACC = 2'd3;

  // Write data select
  localparam logic WD_RDA = 1'b0;
  localparam logic WD_TA  = 1'b1;

  // Sequencing kinds
  localparam logic [1:0] SEQ_NEXT     = 2'd0;
  localparam logic [1:0] SEQ_GOTO     = 2'd1;
  localparam logic [1:0] SEQ_LOOP     = 2'd2;  // to target until the last round
  localparam logic [1:0] SEQ_DISPATCH = 2'd3;

  // Program steps
  localparam pc_t ST_IDLE = 4'd0;
  localparam pc_t ST_LOAD = 4'd1;
  localparam pc_t ST_C1   = 4'd2;
  localparam pc_t ST_C2   = 4'd3;
  localparam pc_t ST_C3   = 4'd4;
  localparam pc_t ST_K0   = 4'd5;
  localparam pc_t ST_K1   = 4'd6;
  localparam pc_t ST_K2   = 4'd7;
  localparam pc_t ST_K3   = 4'd8;
  localparam pc_t ST_K4   = 4'd9;

  typedef struct packed {
    logic       idle;       // open to a new transfer
    logic       key_we;     // write the latched key byte
    logic [1:0] a_sel;
    logic       upd_ij;     // i <= i + 1, j <= j + S[i]
    logic       ld_ta;
    logic       b_rd;       // keystream read on port B
    logic       s_we;
    logic [1:0] w_addr;
    logic       w_data;
    logic       upd_acc;
    logic       sched_clr;  // identity table, zero acc, n, i, j
    logic       step_n;
    logic       emit;       // load the output register
    logic [1:0] seq;
    pc_t        target;
  } ctrl_word_t;

  typedef struct packed {
    logic n_last;
    logic out_free;
  } status_t;

  // Microcode ROM
  function automatic ctrl_word_t ucode_rom(input pc_t pc);
    ctrl_word_t w;
    w = '0;
    unique case (pc)
      ST_IDLE: begin
        w.idle  = 1'b1;
        w.a_sel = A_I1;
        w.seq   = SEQ_DISPATCH;
      end
      ST_LOAD: begin
        w.key_we = 1'b1;
        w.seq    = SEQ_GOTO;
        w.target = ST_IDLE;
      end
      ST_C1: begin
        w.a_sel  = A_JSUM;
        w.upd_ij = 1'b1;
        w.ld_ta  = 1'b1;
        w.seq    = SEQ_NEXT;
      end
      ST_C2: begin
        w.s_we   = 1'b1;
        w.w_addr = W_I;
        w.w_data = WD_RDA;
        w.b_rd   = 1'b1;
        w.seq    = SEQ_NEXT;
      end
      ST_C3: begin
        w.s_we   = 1'b1;
        w.w_addr = W_J;
        w.w_data = WD_TA;
        w.emit   = 1'b1;
        w.seq    = SEQ_GOTO;
        w.target = ST_IDLE;
      end
      ST_K0: begin
        w.sched_clr = 1'b1;
        w.seq       = SEQ_NEXT;
      end
      ST_K1: begin
        w.a_sel = A_N;
        w.seq   = SEQ_NEXT;
      end
      ST_K2: begin
        w.a_sel   = A_KSUM;
        w.upd_acc = 1'b1;
        w.ld_ta   = 1'b1;
        w.seq     = SEQ_NEXT;
      end
      ST_K3: begin
        w.s_we   = 1'b1;
        w.w_addr = W_N;
        w.w_data = WD_RDA;
        w.seq    = SEQ_NEXT;
      end
      ST_K4: begin
        w.s_we   = 1'b1;
        w.w_addr = W_ACC;
        w.w_data = WD_TA;
        w.step_n = 1'b1;
        w.seq    = SEQ_LOOP;
        w.target = ST_K1;
      end
      default: begin
        w.seq    = SEQ_GOTO;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/rc4_sbox.sv =====
// Permutation table: 256 x 8 memory, one write port and two registered read ports.
// Per-entry valid bits make an unwritten entry read as its own index. Uses rc4_pkg.
`default_nettype none

module rc4_sbox import rc4_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  input  wire         clear,
  input  wire  byte_t a_addr,
  output byte_t       a_data,
  input  wire         b_en,
  input  wire  byte_t b_addr,
  output byte_t       b_data,
  input  wire         we,
  input  wire  byte_t waddr,
  input  wire  byte_t wdata
);

  byte_t                 mem [SBOX_DEPTH];
  logic [SBOX_DEPTH-1:0] valid;

  // Track written entries; clear returns the table to identity
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (clear) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read ports, old data on a same-edge write
  always_ff @(posedge clk) begin
    a_data <= valid[a_addr] ? mem[a_addr] : a_addr;
    if (b_en) begin
      b_data <= valid[b_addr] ? mem[b_addr] : b_addr;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rc4_useq.sv =====
// Microcode sequencer: step counter, program ROM lookup and jump logic.
// Depends on rc4_pkg for the control word, status and step codes.
`default_nettype none

module rc4_useq import rc4_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  input  wire         accept,
  input  wire  [1:0]  action,
  input  wire status_t status,
  output ctrl_word_t  ctrl
);

  pc_t pc;
  pc_t pc_next;

  assign ctrl = ucode_rom(pc);

  // Choose the next step
  always_comb begin
    pc_next = pc;
    unique case (ctrl.seq)
      SEQ_NEXT: begin
        pc_next = pc + pc_t'(1);
      end
      SEQ_GOTO: begin
        if (!ctrl.emit || status.out_free) begin
          pc_next = ctrl.target;
        end
      end
      SEQ_LOOP: begin
        pc_next = status.n_last ? ST_IDLE : ctrl.target;
      end
      SEQ_DISPATCH: begin
        pc_next = ST_IDLE;
        if (accept) begin
          unique case (action)
            ACT_LOAD:  pc_next = ST_LOAD;
            ACT_INIT:  pc_next = ST_K0;
            ACT_CRYPT: pc_next = ST_C1;
            default:   pc_next = ST_IDLE;
          endcase
        end
      end
      default: begin
        pc_next = ST_IDLE;
      end
    endcase
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rc4_dpath.sv =====
// Datapath: indices, schedule counters, key store, S-box and output register.
// Driven by the control word from rc4_useq; uses rc4_pkg and instantiates rc4_sbox.
`default_nettype none

module rc4_dpath import rc4_pkg::*; #(
  parameter int KEY_DEPTH = 256
) (
  input  wire             clk,
  input  wire             rst,
  input  wire ctrl_word_t ctrl,
  input  wire             accept,
  input  wire  byte_t     key_index,
  input  wire  byte_t     data_byte,
  input  wire             key_length_we,
  input  wire  [8:0]      key_length_wdata,
  input  wire             out_stall,
  output logic            out_valid,
  output byte_t           out_byte,
  output status_t         status
);

  localparam int KW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

  logic [8:0]    key_length;
  logic [8:0]    klen;
  logic [8:0]    klen_m1;
  byte_t         idx_i;
  byte_t         idx_j;
  byte_t         acc;
  byte_t         n;
  logic [KW-1:0] kpos;
  byte_t         ta;
  byte_t         tb;
  logic          hit_i;
  logic          hit_j;
  byte_t         key_idx_q;
  byte_t         data_q;
  byte_t         krd;
  byte_t         kmem [KEY_DEPTH];

  byte_t a_rd;
  byte_t b_rd;
  byte_t a_addr;
  byte_t b_addr;
  byte_t j_sum;
  byte_t k_sum;
  byte_t waddr;
  byte_t wdata;
  byte_t ks;
  logic  out_free;

  // Key length register
  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= 9'd1;
    end else if (key_length_we) begin
      key_length <= key_length_wdata;
    end
  end

  // Clamp the key length to 1..KEY_DEPTH
  always_comb begin
    if (key_length == 9'd0) begin
      klen = 9'd1;
    end else if (key_length > 9'(KEY_DEPTH)) begin
      klen = 9'(KEY_DEPTH);
    end else begin
      klen = key_length;
    end
    klen_m1 = klen - 9'd1;
  end

  // Hold the payload of the accepted transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      key_idx_q <= key_index;
      data_q    <= data_byte;
    end
  end

  // Key store
  always_ff @(posedge clk) begin
    if (ctrl.key_we && ({1'b0, key_idx_q} < 9'(KEY_DEPTH))) begin
      kmem[key_idx_q[KW-1:0]] <= data_q;
    end
    krd <= kmem[kpos];
  end

  // Address and sum logic
  assign j_sum  = byte_t'(idx_j + a_rd);
  assign k_sum  = byte_t'(acc + a_rd + krd);
  assign b_addr = byte_t'(ta + a_rd);

  always_comb begin
    unique case (ctrl.a_sel)
      A_I1:    a_addr = byte_t'(idx_i + 8'd1);
      A_JSUM:  a_addr = j_sum;
      A_N:     a_addr = n;
      A_KSUM:  a_addr = k_sum;
      default: a_addr = n;
    endcase
    unique case (ctrl.w_addr)
      W_I:     waddr = idx_i;
      W_J:     waddr = idx_j;
      W_N:     waddr = n;
      W_ACC:   waddr = acc;
      default: waddr = n;
    endcase
    wdata = (ctrl.w_data == WD_TA) ? ta : a_rd;
  end

  rc4_sbox u_sbox (
    .clk    (clk),
    .rst    (rst),
    .clear  (ctrl.sched_clr),
    .a_addr (a_addr),
    .a_data (a_rd),
    .b_en   (ctrl.b_rd),
    .b_addr (b_addr),
    .b_data (b_rd),
    .we     (ctrl.s_we),
    .waddr  (waddr),
    .wdata  (wdata)
  );

  // Indices and schedule counters
  always_ff @(posedge clk) begin
    if (rst) begin
      idx_i <= '0;
      idx_j <= '0;
      acc   <= '0;
      n     <= '0;
      kpos  <= '0;
    end else if (ctrl.sched_clr) begin
      idx_i <= '0;
      idx_j <= '0;
      acc   <= '0;
      n     <= '0;
      kpos  <= '0;
    end else begin
      if (ctrl.upd_ij) begin
        idx_i <= byte_t'(idx_i + 8'd1);
        idx_j <= j_sum;
      end
      if (ctrl.upd_acc) begin
        acc <= k_sum;
      end
      if (ctrl.step_n) begin
        n    <= byte_t'(n + 8'd1);
        kpos <= (kpos == klen_m1[KW-1:0]) ? '0 : kpos + KW'(1);
      end
    end
  end

  // Swap operands and keystream bypass flags
  always_ff @(posedge clk) begin
    if (ctrl.ld_ta) begin
      ta <= a_rd;
    end
    if (ctrl.b_rd) begin
      tb    <= a_rd;
      hit_i <= (b_addr == idx_i);
      hit_j <= (b_addr == idx_j);
    end
  end

  // Keystream byte as seen after the swap completes
  assign ks = hit_j ? ta : (hit_i ? tb : b_rd);

  // Output register
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit && out_free) begin
      out_byte <= data_q ^ ks;
    end
  end

  assign status = '{n_last: (n == 8'hFF), out_free: out_free};

endmodule

`default_nettype wire

// ===== hdl/rc4_stream_cipher.sv =====
// RC4 cipher, one item in work at a time. A crypt runs through the idle step, the S[j] read,
// the first swap write with keystream read and the second swap write, which registers its
// result; a key-byte load runs through the idle and load steps, and an init clears the table
// and then reads and swaps each S-box entry in turn. The single-write-port S-box sets these
// steps. A stalled result holds the next crypt in its last step, while loads and inits go on.
// Synchronous reset: identity S-box (via valid bits), i = j = 0, key_length = 1, output empty.
`default_nettype none

module rc4_stream_cipher import rc4_pkg::*; #(
  parameter int KEY_DEPTH = 256
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [1:0] action,
  input  wire  [7:0] key_index,
  input  wire  [7:0] data_byte,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [7:0] out_byte,
  input  wire        key_length_we,
  input  wire  [8:0] key_length_wdata
);

  ctrl_word_t ctrl;
  status_t    status;
  logic       accept;

  // Take a transfer only on the idle step
  assign in_stall = !ctrl.idle;
  assign accept   = in_valid && !in_stall;

  rc4_useq u_useq (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .action (action),
    .status (status),
    .ctrl   (ctrl)
  );

  rc4_dpath #(
    .KEY_DEPTH (KEY_DEPTH)
  ) u_dpath (
    .clk              (clk),
    .rst              (rst),
    .ctrl             (ctrl),
    .accept           (accept),
    .key_index        (key_index),
    .data_byte        (data_byte),
    .key_length_we    (key_length_we),
    .key_length_wdata (key_length_wdata),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_byte         (out_byte),
    .status           (status)
  );

endmodule

`default_nettype wire

// ===== hdl/rc4_checker.sv =====
// Port-level checks for rc4_stream_cipher, attached by the bind at the end.
// Uses rc4_pkg for the action codes.
`default_nettype none

module rc4_checker import rc4_pkg::*; (
  input wire       clk,
  input wire       rst,
  input wire       in_valid,
  input wire       in_stall,
  input wire [1:0] action,
  input wire [7:0] key_index,
  input wire [7:0] data_byte,
  input wire       out_valid,
  input wire       out_stall,
  input wire [7:0] out_byte,
  input wire       key_length_we,
  input wire [8:0] key_length_wdata
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // A held result keeps its byte
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte))
    else $error("stalled result changed");

  // Any real action keeps the input stalled while it works
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && action != ACT_NONE |=> in_stall)
    else $error("input not stalled after an accepted action");

  // A new result appears only at the end of a busy step
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in progress");

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (.*);

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking bench for rc4_stream_cipher: loads key bytes, reruns the key schedule
// and crypts bytes under random idling on both channels, checking every output byte.
// Depends on rc4_pkg (action codes, byte type) and the rc4_stream_cipher RTL.

module tb;
  import rc4_pkg::*;

  localparam int          RST_CYCLES      = 10;
  localparam int          DRAIN_CYCLES    = 1100;  // longer than a full key schedule
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int          NUM_PHASES      = 8;
  localparam int          ITEMS_PER_PHASE = 53;

  // Tracks the cipher state and the output bytes still owed by the block
  class cipher_tracker;
    byte_t       perm[SBOX_DEPTH];
    byte_t       key_bytes[SBOX_DEPTH];
    byte_t       idx_i;
    byte_t       idx_j;
    int unsigned key_len;
    byte_t       owed_bytes[$];
    int unsigned mismatches;

    function new();
      for (int n = 0; n < SBOX_DEPTH; n++) begin
        perm[n]      = byte_t'(n);
        key_bytes[n] = '0;
      end
      idx_i      = '0;
      idx_j      = '0;
      key_len    = 1;
      mismatches = 0;
    endfunction

    function void set_key_length(logic [8:0] v);
      key_len = 32'(v);
    endfunction

    function void swap_perm(byte_t a, byte_t b);
      byte_t t;
      t       = perm[a];
      perm[a] = perm[b];
      perm[b] = t;
    endfunction

    // Rebuild the table from the key, clamping the length to 1..256
    function void rekey();
      int unsigned len;
      byte_t       acc;
      len = (key_len == 0) ? 1 : (key_len > SBOX_DEPTH) ? SBOX_DEPTH : key_len;
      acc = '0;
      for (int n = 0; n < SBOX_DEPTH; n++) perm[n] = byte_t'(n);
      for (int n = 0; n < SBOX_DEPTH; n++) begin
        acc = acc + perm[n] + key_bytes[n % len];
        swap_perm(byte_t'(n), acc);
      end
      idx_i = '0;
      idx_j = '0;
    endfunction

    function byte_t keystream();
      byte_t sum;
      idx_i = idx_i + 8'd1;
      idx_j = idx_j + perm[idx_i];
      swap_perm(idx_i, idx_j);
      sum = perm[idx_i] + perm[idx_j];
      return perm[sum];
    endfunction

    function void note_transfer(logic [1:0] act, byte_t kidx, byte_t data);
      case (act)
        ACT_LOAD:  key_bytes[kidx] = data;
        ACT_INIT:  rekey();
        ACT_CRYPT: owed_bytes.push_back(data ^ keystream());
        default:   ;
      endcase
    endfunction

    function void check_byte(byte_t got);
      byte_t want;
      if (owed_bytes.size() == 0) begin
        $error("out_byte: no result expected, actual %02h", got);
        mismatches++;
      end else begin
        want = owed_bytes.pop_front();
        if (got !== want) begin
          $error("out_byte: expected %02h, actual %02h", want, got);
          mismatches++;
        end
      end
    endfunction

    function int unsigned pending();
      return owed_bytes.size();
    endfunction
  endclass

  logic       clk              = 1'b0;
  logic       rst              = 1'b1;
  logic       in_valid         = 1'b0;
  logic [1:0] action           = ACT_NONE;
  byte_t      key_index        = '0;
  byte_t      data_byte        = '0;
  logic       out_stall        = 1'b0;
  logic       key_length_we    = 1'b0;
  logic [8:0] key_length_wdata = '0;
  wire        in_stall;
  wire        out_valid;
  wire  [7:0] out_byte;

  cipher_tracker tracker;
  bit            key_written[SBOX_DEPTH];
  bit            quiet = 1'b0;
  int unsigned   cycle_count = 0;

  rc4_stream_cipher uut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .action           (action),
    .key_index        (key_index),
    .data_byte        (data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .key_length_we    (key_length_we),
    .key_length_wdata (key_length_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Stall the output in random bursts
  initial begin
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Check every output transfer
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) tracker.check_byte(out_byte);
  end

  // Offer one item, hold it until the transfer, then note it
  task automatic drive_item(logic [1:0] act, byte_t kidx, byte_t data);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    key_index <= kidx;
    data_byte <= data;
    do @(posedge clk); while (in_stall);
    tracker.note_transfer(act, kidx, data);
    if (act == ACT_LOAD) key_written[kidx] = 1'b1;
  endtask

  // Drop valid, collect every owed byte, then let a key schedule run out
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_key_length(logic [8:0] v);
    key_length_we    <= 1'b1;
    key_length_wdata <= v;
    @(posedge clk);
    key_length_we <= 1'b0;
    tracker.set_key_length(v);
  endtask

  // One key length: fill any key bytes the schedule will read, init, then mixed traffic
  task automatic run_phase(logic [8:0] klen, int count);
    int unsigned eff;
    int unsigned pick;
    byte_t       kidx;
    eff = (klen == 9'd0) ? 1 : (klen > 9'(SBOX_DEPTH)) ? SBOX_DEPTH : 32'(klen);
    settle();
    write_key_length(klen);
    for (int n = 0; n < eff; n++) begin
      if (!key_written[n]) drive_item(ACT_LOAD, byte_t'(n), byte_t'($urandom));
    end
    drive_item(ACT_INIT, byte_t'($urandom), byte_t'($urandom));
    repeat (count) begin
      pick = $urandom_range(0, 99);
      // bias key writes towards bytes the schedule actually uses
      kidx = ($urandom_range(0, 3) != 0) ? byte_t'($urandom_range(0, eff - 1))
                                         : byte_t'($urandom);
      if (pick < 25) drive_item(ACT_LOAD, kidx, byte_t'($urandom));
      else if (pick < 31) drive_item(ACT_INIT, kidx, byte_t'($urandom));
      else if (pick < 96) drive_item(ACT_CRYPT, kidx, byte_t'($urandom));
      else drive_item(ACT_NONE, kidx, byte_t'($urandom));
    end
  endtask

  initial begin
    logic [8:0] phase_len[NUM_PHASES];
    tracker = new();
    phase_len = '{9'd0, 9'd511, 9'd256, 9'd255, 9'd2, 9'd37, 9'd0, 9'd0};
    phase_len[6] = 9'($urandom_range(3, 254));
    phase_len[7] = 9'($urandom_range(257, 510));
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Crypt on the identity table before any init, then with a one-byte key
    drive_item(ACT_CRYPT, 8'h00, 8'h00);
    drive_item(ACT_CRYPT, 8'hff, 8'hff);
    drive_item(ACT_NONE,  8'hff, 8'hff);
    drive_item(ACT_LOAD,  8'h00, 8'hff);
    drive_item(ACT_LOAD,  8'hff, 8'h00);
    drive_item(ACT_INIT,  8'h00, 8'h00);
    drive_item(ACT_CRYPT, 8'h00, 8'h00);
    drive_item(ACT_CRYPT, 8'h00, 8'ha5);
    drive_item(ACT_NONE,  8'h00, 8'h00);
    drive_item(ACT_CRYPT, 8'hff, 8'hff);
    drive_item(ACT_LOAD,  8'h00, 8'h00);
    drive_item(ACT_INIT,  8'hff, 8'hff);
    drive_item(ACT_CRYPT, 8'h00, 8'h00);
    drive_item(ACT_CRYPT, 8'h00, 8'h5a);
    drive_item(ACT_CRYPT, 8'h00, 8'hff);

    // Sweep key lengths, zero and oversize among them; no idling in the last phase
    for (int p = 0; p < NUM_PHASES; p++) begin
      quiet = (p == NUM_PHASES - 1);
      run_phase(phase_len[p], ITEMS_PER_PHASE);
    end

    settle();
    if (tracker.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
